// ----- rtl/core/rof_pkg.sv -----
`default_nettype none

package rof_pkg;

   // Store geometry
   localparam int MAX_POINTS = 4096;
   localparam int COORD_BITS = 18;

   // Fixed field widths on the ports
   localparam int IN_COORD_W  = 18;
   localparam int IDX_IN_W    = 12;
   localparam int COUNT_OUT_W = 13;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;

   // Derived widths
   localparam int ADDR_W  = $clog2(MAX_POINTS);
   localparam int TOTAL_W = $clog2(MAX_POINTS + 1);
   localparam int ENTRY_W = 3 * COORD_BITS;
   localparam int DIFF_W  = COORD_BITS + 1;
   localparam int SQ_W    = 2 * COORD_BITS;
   localparam int D2_W    = 2 * COORD_BITS + 2;
   localparam int RNG_W   = (D2_W > 33) ? D2_W : 33;
   localparam int LIM_W   = RNG_W + 1;
   localparam int SAT_W   = 26;
   localparam int COUNT_MAX_OUT = (1 << COUNT_OUT_W) - 1;

   // Action codes
   localparam logic [1:0] ACT_CLEAR    = 2'd0;
   localparam logic [1:0] ACT_APPEND   = 2'd1;
   localparam logic [1:0] ACT_CLASSIFY = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS_MODE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIXED_RADIUS  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_NEIGHBORS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_RADIUS    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS_GAIN   = 3'd4;

   // Register reset values
   localparam logic        RST_RADIUS_MODE   = 1'b0;
   localparam logic [15:0] RST_FIXED_RADIUS  = 16'd500;
   localparam logic [7:0]  RST_MIN_NEIGHBORS = 8'd3;
   localparam logic [15:0] RST_MIN_RADIUS    = 16'd120;
   localparam logic [15:0] RST_RADIUS_GAIN   = 16'd1573;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CENTRE,
      ST_RANGE,
      ST_PROD,
      ST_LIMIT,
      ST_SCAN,
      ST_DONE
   } state_type;

   // Clamp an input coordinate to the stored signed range
   function automatic logic signed [COORD_BITS-1:0] sat_coord(
      input logic signed [IN_COORD_W-1:0] v);
      logic signed [SAT_W-1:0] ext;
      logic signed [SAT_W-1:0] hi;
      logic signed [SAT_W-1:0] lo;
      ext = SAT_W'(v);
      hi  = (SAT_W'(1) <<< (COORD_BITS - 1)) - SAT_W'(1);
      lo  = -hi - SAT_W'(1);
      if (ext > hi) begin
         ext = hi;
      end else if (ext < lo) begin
         ext = lo;
      end
      return COORD_BITS'(ext);
   endfunction

   // Square of a signed difference
   function automatic logic [SQ_W-1:0] sq_mag(input logic signed [DIFF_W-1:0] d);
      logic [DIFF_W-1:0] m;
      m = (d < 0) ? DIFF_W'(-d) : DIFF_W'(d);
      return SQ_W'(m[DIFF_W-2:0]) * SQ_W'(m[DIFF_W-2:0]);
   endfunction

   // Saturate the neighbour count to the output field
   function automatic logic [COUNT_OUT_W-1:0] sat_count(input logic [TOTAL_W-1:0] c);
      logic [31:0] w;
      w = 32'(c);
      if (w > 32'(COUNT_MAX_OUT)) begin
         w = 32'(COUNT_MAX_OUT);
      end
      return COUNT_OUT_W'(w);
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/radius_outlier_filter.sv -----
// Radius outlier filter for a point cloud.
// Request channel (req_*): one word per action. Clear empties the store, append
// stores one point (dropped when the store is full), classify counts every
// stored point whose squared distance to the indexed point is strictly below
// the squared search radius and answers on the response channel (rsp_*).
// Clear and append give no response. A classify with a valid index passes the
// centre, range, product, limit, scan and done states before its response
// word; the scan reads one stored point per cycle through the single read
// port of the point memory. A classify with an index outside the store goes
// straight to done and answers with bad_index set. req_stall is high while
// a classify is in progress; one item at a time. A finished response waits
// in an output register while rsp_stall is high; new requests are still
// taken meanwhile, and the next classify holds its result until that
// register frees up. Configuration (csr_*) is to be written only while the
// block is idle; the block does not enforce this. Reset (synchronous) empties
// the store and loads the default registers; the point memory itself is not
// cleared, and no clearing pass is needed.
`default_nettype none

module radius_outlier_filter (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_stall,
   input  wire logic [1:0]                          req_action,
   input  wire logic signed [rof_pkg::IN_COORD_W-1:0] req_pos_x,
   input  wire logic signed [rof_pkg::IN_COORD_W-1:0] req_pos_y,
   input  wire logic signed [rof_pkg::IN_COORD_W-1:0] req_pos_z,
   input  wire logic [rof_pkg::IDX_IN_W-1:0]        req_point_index,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output      logic                                rsp_is_kept,
   output      logic [rof_pkg::COUNT_OUT_W-1:0]     rsp_neighbor_count,
   output      logic                                rsp_bad_index,
   input  wire logic                                csr_wr_en,
   input  wire logic [rof_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [rof_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import rof_pkg::*;

   state_type state_ff, state_in;

   // Configuration registers
   logic        mode_ff;
   logic [15:0] fix_rad_ff;
   logic [7:0]  min_nb_ff;
   logic [15:0] min_rad_ff;
   logic [15:0] gain_ff;

   // Point memory and its read port
   logic [ENTRY_W-1:0] point_mem [MAX_POINTS];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0]  rd_addr;
   logic               rd_en;
   logic               wr_en;
   logic [ENTRY_W-1:0] wr_data;

   logic [TOTAL_W-1:0] total_ff, total_in;
   logic               accept;
   logic               bad_ff;
   logic               bad_now;

   // Centre point and radius limit
   logic signed [COORD_BITS-1:0] cx_ff, cy_ff, cz_ff;
   logic [SQ_W-1:0]  rsx_ff, rsy_ff, rsz_ff;
   logic [31:0]      g2_ff, floor2_ff, fix2_ff;
   logic [RNG_W-1:0] range2_ff;
   logic [63:0]      lo_prod_ff;
   logic [RNG_W-1:0] hi_prod_ff;
   logic [LIM_W-1:0] limit_ff;
   logic [LIM_W-1:0] scaled_lim;

   // Scan pipeline
   logic [TOTAL_W-1:0] ptr_ff, ptr_in;
   logic [TOTAL_W-1:0] count_ff, count_in;
   logic               v1_ff, v2_ff, v3_ff;
   logic               issue;
   logic               scan_idle;
   logic [SQ_W-1:0]    dsx_ff, dsy_ff, dsz_ff;
   logic [D2_W-1:0]    d2_ff;
   logic signed [COORD_BITS-1:0] ex, ey, ez;

   // Output register
   logic                   rsp_valid_ff;
   logic                   rsp_kept_ff;
   logic [COUNT_OUT_W-1:0] rsp_count_ff;
   logic                   rsp_bad_ff;
   logic                   load_rsp;

   assign accept = req_valid && !req_stall;
   assign ex = $signed(rd_data_ff[ENTRY_W-1 -: COORD_BITS]);
   assign ey = $signed(rd_data_ff[2*COORD_BITS-1 -: COORD_BITS]);
   assign ez = $signed(rd_data_ff[COORD_BITS-1:0]);
   assign wr_data = {sat_coord(req_pos_x), sat_coord(req_pos_y), sat_coord(req_pos_z)};
   assign bad_now = (32'(req_point_index) >= 32'(total_ff)) ||
                    (32'(req_point_index) >= 32'(MAX_POINTS));
   assign issue = (ptr_ff < total_ff);
   assign scan_idle = !issue && !v1_ff && !v2_ff && !v3_ff;
   assign scaled_lim = LIM_W'(hi_prod_ff) + LIM_W'(lo_prod_ff[63:32]) +
                       LIM_W'(lo_prod_ff[31:0] != 32'd0);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_action == ACT_CLASSIFY) begin
               state_in = bad_now ? ST_DONE : ST_CENTRE;
            end
         end
         ST_CENTRE: state_in = ST_RANGE;
         ST_RANGE:  state_in = ST_PROD;
         ST_PROD:   state_in = ST_LIMIT;
         ST_LIMIT:  state_in = ST_SCAN;
         ST_SCAN: begin
            if (scan_idle) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      req_stall = 1'b1;
      rd_en     = 1'b0;
      rd_addr   = ptr_ff[ADDR_W-1:0];
      wr_en     = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            rd_en     = req_valid && req_action == ACT_CLASSIFY;
            rd_addr   = ADDR_W'(req_point_index);
            wr_en     = req_valid && req_action == ACT_APPEND &&
                        32'(total_ff) < 32'(MAX_POINTS);
         end
         ST_SCAN: begin
            rd_en = issue;
         end
         ST_DONE: begin
            load_rsp = !rsp_valid_ff || !rsp_stall;
         end
         default: ;
      endcase
   end

   // Store fill level
   always_comb begin
      total_in = total_ff;
      if (accept) begin
         case (req_action)
            ACT_CLEAR:  total_in = '0;
            ACT_APPEND: if (wr_en) total_in = total_ff + TOTAL_W'(1);
            default:    ;
         endcase
      end
   end

   // Scan pointer and neighbour count
   always_comb begin
      ptr_in   = ptr_ff;
      count_in = count_ff;
      if (state_ff == ST_LIMIT) begin
         ptr_in   = '0;
         count_in = '0;
      end else if (state_ff == ST_SCAN) begin
         if (issue) begin
            ptr_in = ptr_ff + TOTAL_W'(1);
         end
         if (v3_ff && LIM_W'(d2_ff) < limit_ff) begin
            count_in = count_ff + TOTAL_W'(1);
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= RST_RADIUS_MODE;
         fix_rad_ff   <= RST_FIXED_RADIUS;
         min_nb_ff    <= RST_MIN_NEIGHBORS;
         min_rad_ff   <= RST_MIN_RADIUS;
         gain_ff      <= RST_RADIUS_GAIN;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         v1_ff    <= (state_ff == ST_SCAN) && issue;
         v2_ff    <= (state_ff == ST_SCAN) && v1_ff;
         v3_ff    <= (state_ff == ST_SCAN) && v2_ff;
         // hold the word while stalled, drop it once taken
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_RADIUS_MODE:   mode_ff    <= csr_wdata[0];
               CSR_FIXED_RADIUS:  fix_rad_ff <= csr_wdata;
               CSR_MIN_NEIGHBORS: min_nb_ff  <= csr_wdata[7:0];
               CSR_MIN_RADIUS:    min_rad_ff <= csr_wdata;
               CSR_RADIUS_GAIN:   gain_ff    <= csr_wdata;
               default:           ;
            endcase
         end
      end
   end

   // Point memory: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         point_mem[total_ff[ADDR_W-1:0]] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= point_mem[rd_addr];
      end
   end

   // Radius limit datapath
   always_ff @(posedge clock) begin
      if (accept && req_action == ACT_CLASSIFY) begin
         bad_ff <= bad_now;
      end
      // latch the centre and square its coordinates
      if (state_ff == ST_CENTRE) begin
         cx_ff     <= ex;
         cy_ff     <= ey;
         cz_ff     <= ez;
         rsx_ff    <= sq_mag(DIFF_W'(ex));
         rsy_ff    <= sq_mag(DIFF_W'(ey));
         rsz_ff    <= sq_mag(DIFF_W'(ez));
         g2_ff     <= 32'(gain_ff) * 32'(gain_ff);
         floor2_ff <= 32'(min_rad_ff) * 32'(min_rad_ff);
         fix2_ff   <= 32'(fix_rad_ff) * 32'(fix_rad_ff);
      end
      if (state_ff == ST_RANGE) begin
         range2_ff <= RNG_W'(rsx_ff) + RNG_W'(rsy_ff) + RNG_W'(rsz_ff);
      end
      // gain squared times range squared, in two partial products
      if (state_ff == ST_PROD) begin
         lo_prod_ff <= 64'(g2_ff) * 64'(range2_ff[31:0]);
         hi_prod_ff <= RNG_W'(g2_ff) * RNG_W'(range2_ff[RNG_W-1:32]);
      end
      if (state_ff == ST_LIMIT) begin
         if (!mode_ff) begin
            limit_ff <= LIM_W'(fix2_ff);
         end else if (range2_ff < RNG_W'(floor2_ff)) begin
            limit_ff <= LIM_W'(floor2_ff);
         end else begin
            limit_ff <= scaled_lim;
         end
      end
   end

   // Scan datapath: square differences, then sum
   always_ff @(posedge clock) begin
      ptr_ff   <= ptr_in;
      count_ff <= count_in;
      dsx_ff   <= sq_mag(DIFF_W'(ex) - DIFF_W'(cx_ff));
      dsy_ff   <= sq_mag(DIFF_W'(ey) - DIFF_W'(cy_ff));
      dsz_ff   <= sq_mag(DIFF_W'(ez) - DIFF_W'(cz_ff));
      d2_ff    <= D2_W'(dsx_ff) + D2_W'(dsy_ff) + D2_W'(dsz_ff);
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         if (bad_ff) begin
            rsp_kept_ff  <= 1'b0;
            rsp_count_ff <= '0;
            rsp_bad_ff   <= 1'b1;
         end else begin
            rsp_kept_ff  <= 32'(count_ff) >= 32'(min_nb_ff);
            rsp_count_ff <= sat_count(count_ff);
            rsp_bad_ff   <= 1'b0;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_is_kept        = rsp_kept_ff;
   assign rsp_neighbor_count = rsp_count_ff;
   assign rsp_bad_index      = rsp_bad_ff;

endmodule

`default_nettype wire

// ----- rtl/core/rof_checker.sv -----
`default_nettype none

module rof_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_stall,
   input wire logic [1:0]                          req_action,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_stall,
   input wire logic                                rsp_is_kept,
   input wire logic [rof_pkg::COUNT_OUT_W-1:0]     rsp_neighbor_count,
   input wire logic                                rsp_bad_index
);
   import rof_pkg::*;

   // No response word survives reset
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // Hold a stalled response word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_is_kept) &&
      $stable(rsp_neighbor_count) && $stable(rsp_bad_index))
      else $error("stalled response changed");

   // A bad index carries an empty answer
   a_bad_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_index |-> !rsp_is_kept && rsp_neighbor_count == '0)
      else $error("bad index with non-empty answer");

   // Clear and append never raise a response word
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_action != ACT_CLASSIFY |=> !$rose(rsp_valid))
      else $error("response after clear or append");

endmodule

bind radius_outlier_filter rof_checker u_rof_checker (.*);

`default_nettype wire
